/* src/bpfl_pkg.sv */
// Package for the buffer pool free list: field widths, command, status and
// register index codes. No dependencies.
package bpfl_pkg;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 8;
   localparam int ADDR_W     = 33;
   localparam int CAP_W      = 21;
   localparam int BSIZE_W    = 21;
   localparam int NBUF_W     = 9;
   localparam int BASE_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT    = 2'd0,
      CMD_ACQUIRE = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_REJECT = 2'd2
   } status_type;

   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SIZE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BUFFERS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd2;

   localparam logic [BSIZE_W-1:0] BSIZE_RESET = 21'd2048;
   localparam logic [NBUF_W-1:0]  NBUF_RESET  = 9'd256;

endpackage

/* src/bpfl_if.sv */
// Request and response channel interfaces of the buffer pool free list.
// Depends on bpfl_pkg for field widths.
interface bpfl_req_if
   import bpfl_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [INDEX_W-1:0] release_index;

   modport source (output valid, cmd, release_index, input ready);
   modport sink   (input valid, cmd, release_index, output ready);
endinterface

interface bpfl_rsp_if
   import bpfl_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [INDEX_W-1:0] buffer_index;
   logic [ADDR_W-1:0]  buffer_address;
   logic [CAP_W-1:0]   buffer_capacity;

   modport source (output valid, status, buffer_index, buffer_address, buffer_capacity,
                   input ready);
   modport sink   (input valid, status, buffer_index, buffer_address, buffer_capacity,
                   output ready);
endinterface

/* src/buffer_pool_free_list_unit.sv */
// Top level of the buffer pool free list allocator.
// Depends on bpfl_pkg and the channel interfaces in bpfl_if.sv.
//
//  channel   dir  word                                          handshake
//  req_chan  in   cmd, release_index                            valid/ready
//  rsp_chan  out  status, buffer_index, buffer_address, cap.    valid/ready
//  csr_*     in   csr_index, csr_write_data                     csr_write_enable
//
// One word is taken per cycle while the response side does not stall; each
// gives one response through the decision stage and the output register.
// The response path runs through the registered read port of the
// released-index queue memory, then the index-times-size multiply into the
// output register. Reset is synchronous; it empties the free list to its
// fresh state, so no clearing pass runs. A stalled response holds the output
// register and the decision stage; the request side keeps taking words while the decision stage can move.
module buffer_pool_free_list_unit
   import bpfl_pkg::*;
   #(
      parameter int MAX_BUFFERS = 256
   ) (
      input  logic                  clock,
      input  logic                  reset,
      bpfl_req_if.sink              req_chan,
      bpfl_rsp_if.source            rsp_chan,
      input  logic                  csr_write_enable,
      input  logic [CSR_IDX_W-1:0]  csr_index,
      input  logic [CSR_DATA_W-1:0] csr_write_data
   );

   // count width holds 0..MAX_BUFFERS, pointer width indexes the queue
   localparam int CNTW  = $clog2(MAX_BUFFERS + 1);
   localparam int PW    = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam int IDXW  = (CNTW > INDEX_W) ? CNTW : INDEX_W;
   localparam int MSBW  = $clog2(CNTW + 1);
   localparam int PRODW = IDXW + BSIZE_W;

   // configuration registers
   logic [BSIZE_W-1:0] buffer_size_ff;
   logic [NBUF_W-1:0]  num_buffers_ff;
   logic [BASE_W-1:0]  base_address_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff  <= BSIZE_RESET;
         num_buffers_ff  <= NBUF_RESET;
         base_address_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BUFFER_SIZE:  buffer_size_ff  <= csr_write_data[BSIZE_W-1:0];
            CSR_NUM_BUFFERS:  num_buffers_ff  <= csr_write_data[NBUF_W-1:0];
            CSR_BASE_ADDRESS: base_address_ff <= csr_write_data[BASE_W-1:0];
            default: ;  // unused index: drop the write
         endcase
      end
   end

   // free list state
   logic [CNTW-1:0] fresh_count_ff,  fresh_count_in;
   logic [CNTW-1:0] queued_count_ff, queued_count_in;
   logic [PW-1:0]   rd_ptr_ff,       rd_ptr_in;
   logic [PW-1:0]   wr_ptr_ff,       wr_ptr_in;

   // released-index queue
   logic [INDEX_W-1:0] queue_mem [MAX_BUFFERS];
   logic [INDEX_W-1:0] mem_q_ff;

   // decision stage
   logic               s1_valid_ff;
   status_type         s1_status_ff,     s1_status_in;
   logic               s1_got_ff,        s1_got_in;
   logic               s1_from_queue_ff, s1_from_queue_in;
   logic [IDXW-1:0]    s1_fresh_idx_ff;

   // output register
   logic               out_valid_ff;
   status_type         out_status_ff,   out_status_in;
   logic [INDEX_W-1:0] out_index_ff,    out_index_in;
   logic [ADDR_W-1:0]  out_address_ff,  out_address_in;
   logic [CAP_W-1:0]   out_capacity_ff, out_capacity_in;

   logic s1_advance;
   logic accept;
   logic push;

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   // effective pool size, clamped to 1..MAX_BUFFERS
   logic [CNTW-1:0] pool_n;
   always_comb begin
      if (num_buffers_ff == '0) begin
         pool_n = CNTW'(1);
      end else if (32'(num_buffers_ff) > 32'(MAX_BUFFERS)) begin
         pool_n = CNTW'(MAX_BUFFERS);
      end else begin
         pool_n = CNTW'(num_buffers_ff);
      end
   end

   // list capacity: next power of two at or above the pool size, 2..MAX_BUFFERS
   logic [CNTW-1:0] pool_nm1;
   logic [MSBW-1:0] nm1_len;
   logic [CNTW:0]   list_cap;
   always_comb begin
      pool_nm1 = pool_n - 1'b1;
      nm1_len  = '0;
      for (int i = 0; i < CNTW; i++) begin
         if (pool_nm1[i]) nm1_len = MSBW'(i + 1);
      end
      list_cap = (CNTW + 1)'(1) << nm1_len;
      if (list_cap < (CNTW + 1)'(2)) list_cap = (CNTW + 1)'(2);
      if (32'(list_cap) > 32'(MAX_BUFFERS)) list_cap = (CNTW + 1)'(MAX_BUFFERS);
   end

   logic [CNTW-1:0] fresh_left;
   logic [CNTW:0]   list_used;
   logic            fresh_avail;
   logic            release_bad;

   assign fresh_avail = fresh_count_ff < pool_n;
   assign fresh_left  = fresh_avail ? (pool_n - fresh_count_ff) : '0;
   assign list_used   = (CNTW + 1)'(fresh_left) + (CNTW + 1)'(queued_count_ff);
   assign release_bad = (32'(req_chan.release_index) >= 32'(pool_n))
                        || (list_used >= list_cap);

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      ptr_next = (32'(p) == 32'(MAX_BUFFERS - 1)) ? '0 : p + 1'b1;
   endfunction

   // decide the command against the current list state
   always_comb begin
      fresh_count_in   = fresh_count_ff;
      queued_count_in  = queued_count_ff;
      rd_ptr_in        = rd_ptr_ff;
      wr_ptr_in        = wr_ptr_ff;
      s1_status_in     = STATUS_OK;
      s1_got_in        = 1'b0;
      s1_from_queue_in = 1'b0;
      push             = 1'b0;
      case (req_chan.cmd)
         CMD_INIT: begin
            fresh_count_in  = '0;
            queued_count_in = '0;
            rd_ptr_in       = '0;
            wr_ptr_in       = '0;
         end
         CMD_ACQUIRE: begin
            if (fresh_avail) begin
               fresh_count_in = fresh_count_ff + 1'b1;
               s1_got_in      = 1'b1;
            end else if (queued_count_ff != '0) begin
               rd_ptr_in        = ptr_next(rd_ptr_ff);
               queued_count_in  = queued_count_ff - 1'b1;
               s1_got_in        = 1'b1;
               s1_from_queue_in = 1'b1;
            end else begin
               s1_status_in = STATUS_EMPTY;
            end
         end
         CMD_RELEASE: begin
            if (release_bad) begin
               s1_status_in = STATUS_REJECT;
            end else begin
               push            = 1'b1;
               wr_ptr_in       = ptr_next(wr_ptr_ff);
               queued_count_in = queued_count_ff + 1'b1;
            end
         end
         default: ;  // unused command: no state change, plain ok response
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_count_ff  <= '0;
         queued_count_ff <= '0;
         rd_ptr_ff       <= '0;
         wr_ptr_ff       <= '0;
         s1_valid_ff     <= 1'b0;
      end else begin
         if (accept) begin
            fresh_count_ff  <= fresh_count_in;
            queued_count_ff <= queued_count_in;
            rd_ptr_ff       <= rd_ptr_in;
            wr_ptr_ff       <= wr_ptr_in;
            s1_valid_ff     <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff     <= 1'b0;
         end
      end
   end

   // decision payload; held while the output side stalls
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff     <= s1_status_in;
         s1_got_ff        <= s1_got_in;
         s1_from_queue_ff <= s1_from_queue_in;
         s1_fresh_idx_ff  <= IDXW'(fresh_count_ff);
      end
   end

   // queue write port
   always_ff @(posedge clock) begin
      if (accept && push) begin
         queue_mem[wr_ptr_ff] <= req_chan.release_index;
      end
   end

   // queue read port, registered; only an acquire served from the queue reads
   always_ff @(posedge clock) begin
      if (accept && s1_from_queue_in) begin
         mem_q_ff <= queue_mem[rd_ptr_ff];
      end
   end

   // address: base plus index times size, modulo 2^33
   logic [IDXW-1:0]  grant_idx;
   logic [PRODW-1:0] grant_prod;

   assign grant_idx  = s1_from_queue_ff ? IDXW'(mem_q_ff) : s1_fresh_idx_ff;
   assign grant_prod = PRODW'(grant_idx) * PRODW'(buffer_size_ff);

   always_comb begin
      out_status_in   = s1_status_ff;
      out_index_in    = '0;
      out_address_in  = '0;
      out_capacity_in = '0;
      if (s1_got_ff) begin
         out_index_in    = grant_idx[INDEX_W-1:0];
         out_address_in  = ADDR_W'(base_address_ff) + ADDR_W'(grant_prod);
         out_capacity_in = CAP_W'(buffer_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_status_ff   <= out_status_in;
         out_index_ff    <= out_index_in;
         out_address_ff  <= out_address_in;
         out_capacity_ff <= out_capacity_in;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.status          = out_status_ff;
   assign rsp_chan.buffer_index    = out_index_ff;
   assign rsp_chan.buffer_address  = out_address_ff;
   assign rsp_chan.buffer_capacity = out_capacity_ff;

   // the queued count never exceeds the queue depth, MAX_BUFFERS
   a_queued_bound: assert property (@(posedge clock) disable iff (reset)
      32'(queued_count_ff) <= 32'(MAX_BUFFERS))
      else $error("queued count above queue depth");

   // write pointer leads read pointer by the queued count
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      32'(wr_ptr_ff) == ((32'(rd_ptr_ff) + 32'(queued_count_ff)) % MAX_BUFFERS))
      else $error("queue pointers and count disagree");

   // init empties the list back to its fresh state
   a_init_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req_chan.cmd == CMD_INIT)
      |=> (fresh_count_ff == '0) && (queued_count_ff == '0))
      else $error("init left list state behind");

   // an acquire served from the queue consumes exactly one entry
   a_pop_one: assert property (@(posedge clock) disable iff (reset)
      accept && s1_from_queue_in
      |=> queued_count_ff == $past(queued_count_ff) - 1'b1)
      else $error("queue pop miscounted");

   // a decision waiting on a stalled output holds its payload
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance
      |=> s1_valid_ff && $stable(s1_status_ff) && $stable(s1_got_ff)
          && $stable(s1_fresh_idx_ff))
      else $error("decision stage lost its word under stall");

endmodule
